/* hdl/wsd_pkg.sv */
package wsd_pkg;

    localparam int HEADER_BYTES = 8;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_ID      = 2'd1;
    localparam logic [1:0] PH_LEN     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MAGIC   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_ID      = 3'd3;
    localparam logic [2:0] ST_LONG    = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;

    localparam logic [7:0] MAX_ID = 8'd12;
    localparam logic [2:0] HEADER_LAST = 3'(HEADER_BYTES - 1);
    localparam logic [2:0] LEN_LAST_SHIFT = 3'd4;

    typedef struct packed {
        logic [1:0]  phase;
        logic [2:0]  header_count;
        logic [31:0] length_accum;
        logic [2:0]  length_shift;
        logic [3:0]  current_id;
        logic [31:0] payload_left;
        logic [31:0] byte_offset;
        logic        error_latched;
    } state_t;

    typedef struct packed {
        logic [3:0]  sect_kind;
        logic [31:0] payload_len;
        logic [31:0] payload_offset;
        logic [2:0]  status;
        logic        end_of_module;
    } rec_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_HEADER,
        header_count:  3'd0,
        length_accum:  32'd0,
        length_shift:  3'd0,
        current_id:    4'd0,
        payload_left:  32'd0,
        byte_offset:   32'd0,
        error_latched: 1'b0
    };

    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h00;
            3'd1:    val = 8'h61;
            3'd2:    val = 8'h73;
            3'd3:    val = 8'h6D;
            3'd4:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* hdl/wsd_if.sv */
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsd_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  sect_kind;
    logic [31:0] payload_len;
    logic [31:0] payload_offset;
    logic [2:0]  status;
    logic        end_of_module;

    modport source (
        output valid, output sect_kind, output payload_len,
        output payload_offset, output status, output end_of_module, input ready
    );
    modport sink (
        input valid, input sect_kind, input payload_len,
        input payload_offset, input status, input end_of_module, output ready
    );
endinterface

/* hdl/wsd_step.sv */
module wsd_step (
    input  wsd_pkg::state_t cur,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output wsd_pkg::state_t nxt,
    output logic            emit,
    output wsd_pkg::rec_t   rec
);

    always_comb
    begin
        logic        fail_en;
        logic [2:0]  fail_st;
        logic [31:0] accum_new;
        logic [31:0] left_new;

        nxt       = cur;
        emit      = 1'b0;
        rec       = '0;
        fail_en   = 1'b0;
        fail_st   = wsd_pkg::ST_OK;
        accum_new = cur.length_accum;
        left_new  = cur.payload_left - 32'd1;

        if (!cur.error_latched)
        begin
            unique case (cur.phase)
                wsd_pkg::PH_HEADER:
                begin
                    if (data_byte != wsd_pkg::header_byte(cur.header_count))
                    begin
                        fail_en = 1'b1;
                        fail_st = cur.header_count[2] ? wsd_pkg::ST_VERSION
                                                      : wsd_pkg::ST_MAGIC;
                    end
                    else if (cur.header_count == wsd_pkg::HEADER_LAST)
                    begin
                        nxt.phase = wsd_pkg::PH_ID;
                        if (last_byte)
                        begin
                            emit              = 1'b1;
                            rec.status        = wsd_pkg::ST_OK;
                            rec.end_of_module = 1'b1;
                        end
                    end
                    else
                    begin
                        nxt.header_count = cur.header_count + 3'd1;
                        if (last_byte)
                        begin
                            fail_en = 1'b1;
                            fail_st = wsd_pkg::ST_TRUNC;
                        end
                    end
                end
                wsd_pkg::PH_ID:
                begin
                    nxt.length_accum = 32'd0;
                    nxt.length_shift = 3'd0;
                    if (data_byte > wsd_pkg::MAX_ID)
                    begin
                        nxt.current_id = 4'd0;
                        fail_en        = 1'b1;
                        fail_st        = wsd_pkg::ST_ID;
                    end
                    else
                    begin
                        nxt.current_id = data_byte[3:0];
                        nxt.phase      = wsd_pkg::PH_LEN;
                        if (last_byte)
                        begin
                            fail_en = 1'b1;
                            fail_st = wsd_pkg::ST_TRUNC;
                        end
                    end
                end
                wsd_pkg::PH_LEN:
                begin
                    unique case (cur.length_shift)
                        3'd0:    accum_new = cur.length_accum | {25'd0, data_byte[6:0]};
                        3'd1:    accum_new = cur.length_accum
                                           | {18'd0, data_byte[6:0], 7'd0};
                        3'd2:    accum_new = cur.length_accum
                                           | {11'd0, data_byte[6:0], 14'd0};
                        3'd3:    accum_new = cur.length_accum
                                           | {4'd0, data_byte[6:0], 21'd0};
                        default: accum_new = cur.length_accum | {data_byte[3:0], 28'd0};
                    endcase
                    priority if (cur.length_shift >= wsd_pkg::LEN_LAST_SHIFT
                                 && data_byte[7:4] != 4'd0)
                    begin
                        fail_en = 1'b1;
                        fail_st = wsd_pkg::ST_LONG;
                    end
                    else if (cur.length_shift < wsd_pkg::LEN_LAST_SHIFT && data_byte[7])
                    begin
                        nxt.length_accum = accum_new;
                        nxt.length_shift = cur.length_shift + 3'd1;
                        if (last_byte)
                        begin
                            fail_en = 1'b1;
                            fail_st = wsd_pkg::ST_TRUNC;
                        end
                    end
                    else if (accum_new != 32'd0 && last_byte)
                    begin
                        nxt.length_accum = accum_new;
                        fail_en          = 1'b1;
                        fail_st          = wsd_pkg::ST_TRUNC;
                    end
                    else
                    begin
                        nxt.length_accum   = accum_new;
                        nxt.payload_left   = accum_new;
                        nxt.phase          = (accum_new == 32'd0) ? wsd_pkg::PH_ID
                                                                  : wsd_pkg::PH_PAYLOAD;
                        emit               = 1'b1;
                        rec.sect_kind      = cur.current_id;
                        rec.payload_len    = accum_new;
                        rec.payload_offset = cur.byte_offset + 32'd1;
                        rec.status         = wsd_pkg::ST_OK;
                        rec.end_of_module  = last_byte;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    nxt.payload_left = left_new;
                    if (left_new == 32'd0)
                    begin
                        nxt.phase = wsd_pkg::PH_ID;
                        if (last_byte)
                        begin
                            emit              = 1'b1;
                            rec.status        = wsd_pkg::ST_OK;
                            rec.end_of_module = 1'b1;
                        end
                    end
                    else if (last_byte)
                    begin
                        fail_en = 1'b1;
                        fail_st = wsd_pkg::ST_TRUNC;
                    end
                end
            endcase
        end

        if (fail_en)
        begin
            nxt.error_latched  = 1'b1;
            emit               = 1'b1;
            rec.sect_kind      = nxt.current_id;
            rec.payload_len    = nxt.length_accum;
            rec.payload_offset = cur.byte_offset;
            rec.status         = fail_st;
            rec.end_of_module  = 1'b0;
        end

        nxt.byte_offset = cur.byte_offset + 32'd1;

        if (last_byte)
        begin
            nxt = wsd_pkg::STATE_RESET;
        end
    end

endmodule

/* hdl/wasm_section_deframer_core.sv */
// Byte-serial WebAssembly section deframer: takes one module-file byte per beat, checks the
// magic and version, then for each section emits one record (id, ULEB128 length, payload
// offset) as soon as its length is decoded, plus a clean end-of-module record and error
// records for bad magic, bad version, unknown id, overlong length and truncation. After an
// error, bytes are dropped up to the last byte of the file; the byte after a last byte starts
// a new file. It sustains one byte per clock while no record waits on the output: each byte
// passes an input register, a combinational state update and a record register, so a record
// is presented once the byte causing it has moved on from the input register. Bytes are only
// held back while a finished record waits on the output.
module wasm_section_deframer_core (
    input  logic              clk,
    input  logic              rst_n,
    wsd_byte_if.sink          in_beat,
    wsd_rec_if.source         out_beat
);

    logic            in_valid_reg;
    logic [7:0]      in_data_reg;
    logic            in_last_reg;
    wsd_pkg::state_t state_reg;
    wsd_pkg::state_t state_next;
    logic            step_emit;
    wsd_pkg::rec_t   step_rec;
    logic            out_valid_reg;
    logic            out_valid_next;
    wsd_pkg::rec_t   out_rec_reg;
    logic            advance;

    assign advance       = in_valid_reg && (!out_valid_reg || out_beat.ready);
    assign in_beat.ready = !in_valid_reg || advance;

    wsd_step u_step (
        .cur       (state_reg),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .emit      (step_emit),
        .rec       (step_rec)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step_emit;
        end
        else if (out_beat.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= wsd_pkg::STATE_RESET;
        end
        else
        begin
            if (in_beat.ready)
            begin
                in_valid_reg <= in_beat.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat.ready && in_beat.valid)
        begin
            in_data_reg <= in_beat.data_byte;
            in_last_reg <= in_beat.last_byte;
        end
        if (advance && step_emit)
        begin
            out_rec_reg <= step_rec;
        end
    end

    assign out_beat.valid          = out_valid_reg;
    assign out_beat.sect_kind      = out_rec_reg.sect_kind;
    assign out_beat.payload_len    = out_rec_reg.payload_len;
    assign out_beat.payload_offset = out_rec_reg.payload_offset;
    assign out_beat.status         = out_rec_reg.status;
    assign out_beat.end_of_module  = out_rec_reg.end_of_module;

`ifndef SYNTH
    // latched error stays silent
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.error_latched |-> !step_emit)
    else $error("record emitted after latched error");

    // last byte returns to a fresh header
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg.phase == wsd_pkg::PH_HEADER
            && state_reg.header_count == 3'd0 && !state_reg.error_latched)
    else $error("state not cleared after last byte");

    // held byte is not lost while the record slot is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg)
            && $stable(in_last_reg))
    else $error("held byte dropped");

    // good records carry a defined section id
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rec_reg.status == wsd_pkg::ST_OK
            |-> {4'd0, out_rec_reg.sect_kind} <= wsd_pkg::MAX_ID)
    else $error("record with undefined section id");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [63:0] WASM_PREAMBLE = 64'h0061736D_01000000;

    typedef enum int {
        FILE_GOOD,
        FILE_CUT,
        FILE_BAD_ID,
        FILE_OVERLONG,
        FILE_CORRUPT,
        FILE_NOISE
    } file_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic stall_en = 1'b1;
    int   cycle_count = 0;
    int   mismatch_count = 0;

    wsd_byte_if byte_bus ();
    wsd_rec_if  rec_bus ();

    wasm_section_deframer_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (byte_bus),
        .out_beat (rec_bus)
    );

    always #1 clk = ~clk;

    // parser state mirrored beat by beat
    logic [1:0]           ph;
    logic [2:0]           hdr_idx;
    logic [31:0]          len_acc;
    logic [2:0]           len_grp;
    logic [3:0]           sec_id;
    logic [31:0]          bytes_left;
    logic [31:0]          file_pos;
    logic                 err_seen;
    wsd_pkg::rec_t        pending_records[$];
    logic [7:0]           file_bytes[$];

    function automatic logic [7:0] preamble_byte(int idx);
        return WASM_PREAMBLE[63 - 8 * idx -: 8];
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    task automatic reset_parser();
        ph         = wsd_pkg::PH_HEADER;
        hdr_idx    = 3'd0;
        len_acc    = 32'd0;
        len_grp    = 3'd0;
        sec_id     = 4'd0;
        bytes_left = 32'd0;
        file_pos   = 32'd0;
        err_seen   = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic lst);
        logic          fault;
        logic [2:0]    fcode;
        logic          emit;
        wsd_pkg::rec_t rec;
        logic [2:0]    s;
        fault = 1'b0;
        fcode = wsd_pkg::ST_OK;
        emit  = 1'b0;
        rec   = '0;
        if (!err_seen)
        begin
            case (ph)
                wsd_pkg::PH_HEADER:
                begin
                    if (b != preamble_byte(hdr_idx))
                    begin
                        fault = 1'b1;
                        fcode = (hdr_idx < 3'd4) ? wsd_pkg::ST_MAGIC : wsd_pkg::ST_VERSION;
                    end
                    else if (hdr_idx == wsd_pkg::HEADER_LAST)
                    begin
                        ph = wsd_pkg::PH_ID;
                        if (lst)
                        begin
                            emit = 1'b1;
                            rec  = '{4'd0, 32'd0, 32'd0, wsd_pkg::ST_OK, 1'b1};
                        end
                    end
                    else
                    begin
                        hdr_idx = hdr_idx + 3'd1;
                        if (lst)
                        begin
                            fault = 1'b1;
                            fcode = wsd_pkg::ST_TRUNC;
                        end
                    end
                end
                wsd_pkg::PH_ID:
                begin
                    len_acc = 32'd0;
                    len_grp = 3'd0;
                    if (b > wsd_pkg::MAX_ID)
                    begin
                        sec_id = 4'd0;
                        fault  = 1'b1;
                        fcode  = wsd_pkg::ST_ID;
                    end
                    else
                    begin
                        sec_id = b[3:0];
                        ph     = wsd_pkg::PH_LEN;
                        if (lst)
                        begin
                            fault = 1'b1;
                            fcode = wsd_pkg::ST_TRUNC;
                        end
                    end
                end
                wsd_pkg::PH_LEN:
                begin
                    s = len_grp;
                    if (s >= wsd_pkg::LEN_LAST_SHIFT && b[7:4] != 4'd0)
                    begin
                        fault = 1'b1;
                        fcode = wsd_pkg::ST_LONG;
                    end
                    else
                    begin
                        if (s >= wsd_pkg::LEN_LAST_SHIFT)
                            len_acc = len_acc | {b[3:0], 28'd0};
                        else
                            len_acc = len_acc | (32'(b[6:0]) << (7 * s));
                        if (s < wsd_pkg::LEN_LAST_SHIFT && b[7])
                        begin
                            len_grp = s + 3'd1;
                            if (lst)
                            begin
                                fault = 1'b1;
                                fcode = wsd_pkg::ST_TRUNC;
                            end
                        end
                        else if (len_acc != 32'd0 && lst)
                        begin
                            fault = 1'b1;
                            fcode = wsd_pkg::ST_TRUNC;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            rec        = '{sec_id, len_acc, file_pos + 32'd1,
                                           wsd_pkg::ST_OK, lst};
                            bytes_left = len_acc;
                            ph         = (len_acc == 32'd0) ? wsd_pkg::PH_ID
                                                            : wsd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 32'd0)
                    begin
                        ph = wsd_pkg::PH_ID;
                        if (lst)
                        begin
                            emit = 1'b1;
                            rec  = '{4'd0, 32'd0, 32'd0, wsd_pkg::ST_OK, 1'b1};
                        end
                    end
                    else if (lst)
                    begin
                        fault = 1'b1;
                        fcode = wsd_pkg::ST_TRUNC;
                    end
                end
            endcase
            if (fault)
            begin
                emit     = 1'b1;
                rec      = '{sec_id, len_acc, file_pos, fcode, 1'b0};
                err_seen = 1'b1;
            end
        end
        if (emit)
            pending_records.insert(pending_records.size(), rec);
        file_pos = file_pos + 32'd1;
        if (lst)
            reset_parser();
    endtask

    // file building
    function automatic int uleb_size(logic [31:0] v);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 32'd0)
            n++;
        return n;
    endfunction

    function automatic void put_section(logic [7:0] id, logic [31:0] len, int nb, int body);
        logic [7:0] grp;
        add_byte(id);
        for (int g = 0; g < nb; g++)
        begin
            grp = 8'((len >> (7 * g)) & 32'h7F);
            if (g < nb - 1)
                grp[7] = 1'b1;
            add_byte(grp);
        end
        repeat (body) add_byte(8'($urandom));
    endfunction

    function automatic void build_file(file_kind_t kind);
        int          nsec;
        int          nb;
        int          keep;
        int          pos;
        logic [31:0] len;
        file_bytes.delete();
        if (kind == FILE_NOISE)
        begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            return;
        end
        for (int i = 0; i < wsd_pkg::HEADER_BYTES; i++)
            add_byte(preamble_byte(i));
        nsec = (kind == FILE_GOOD || kind == FILE_CORRUPT) ? $urandom_range(0, 4)
                                                           : $urandom_range(0, 2);
        repeat (nsec)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 120) : $urandom_range(0, 6);
            nb  = uleb_size(len);
            if ($urandom_range(0, 2) == 0)
                nb = nb + $urandom_range(0, 5 - nb);
            put_section(8'($urandom_range(0, 12)), len, nb, int'(len));
        end
        case (kind)
            FILE_CUT:
            begin
                len = $urandom;
                nb  = uleb_size(len);
                nb  = nb + $urandom_range(0, 5 - nb);
                put_section(8'($urandom_range(0, 12)), len, nb, $urandom_range(0, 3));
                keep = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep)
                    void'(file_bytes.pop_back());
            end
            FILE_BAD_ID:
            begin
                add_byte(8'($urandom_range(13, 255)));
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            end
            FILE_OVERLONG:
            begin
                add_byte(8'($urandom_range(0, 12)));
                repeat (4) add_byte(8'h80 | 8'($urandom_range(0, 127)));
                add_byte(8'($urandom_range(16, 255)));
                repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
            end
            FILE_CORRUPT:
            begin
                if ($urandom_range(0, 1) == 0)
                    pos = $urandom_range(0, wsd_pkg::HEADER_BYTES - 1);
                else
                    pos = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[pos] = 8'($urandom);
            end
            default:
            begin
            end
        endcase
    endfunction

    // byte side
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (stall_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            byte_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= b;
        byte_bus.last_byte <= lst;
        @(posedge clk);
        while (!byte_bus.ready)
            @(posedge clk);
        deframe_byte(b, lst);
        @(negedge clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending_records.size() != 0)
            @(negedge clk);
    endtask

    // record side
    initial
    begin : sink_side
        int hold;
        hold = 0;
        rec_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && stall_en && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 4);
            rec_bus.ready <= (hold == 0);
            if (hold > 0)
                hold--;
        end
    end

    task automatic report_mismatch(string what, wsd_pkg::rec_t want, wsd_pkg::rec_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s: expected id=%0d len=%h off=%h st=%0d end=%0b",
                     what, want.sect_kind, want.payload_len, want.payload_offset,
                     want.status, want.end_of_module);
            $display("    got id=%0d len=%h off=%h st=%0d end=%0b",
                     got.sect_kind, got.payload_len, got.payload_offset,
                     got.status, got.end_of_module);
        end
    endtask

    always @(posedge clk)
    begin : check_records
        wsd_pkg::rec_t got;
        wsd_pkg::rec_t want;
        if (rst_n && rec_bus.valid && rec_bus.ready)
        begin
            got = '{rec_bus.sect_kind, rec_bus.payload_len, rec_bus.payload_offset,
                    rec_bus.status, rec_bus.end_of_module};
            if (pending_records.size() == 0)
            begin
                report_mismatch("unexpected record", '0, got);
            end
            else
            begin
                want = pending_records.pop_front();
                if (got.sect_kind !== want.sect_kind
                    || got.payload_len !== want.payload_len
                    || got.payload_offset !== want.payload_offset
                    || got.status !== want.status
                    || got.end_of_module !== want.end_of_module)
                    report_mismatch("record mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // tests
    task automatic test_bad_magic();
        file_bytes.delete();
        add_byte(8'hFF);
        send_file();
    endtask

    task automatic test_bad_version_on_last();
        file_bytes.delete();
        for (int i = 0; i < 4; i++)
            add_byte(preamble_byte(i));
        add_byte(8'h80);
        send_file();
    endtask

    task automatic test_empty_final_section();
        file_bytes.delete();
        for (int i = 0; i < wsd_pkg::HEADER_BYTES; i++)
            add_byte(preamble_byte(i));
        put_section(8'(wsd_pkg::MAX_ID), 32'd0, 1, 0);
        send_file();
    endtask

    task automatic test_drain_pause();
        build_file(FILE_GOOD);
        send_file();
        wait_drained();
    endtask

    task automatic test_random_files(int target);
        int         sent;
        int         k;
        file_kind_t kind;
        sent = 0;
        k    = $urandom_range(0, 9);
        while (sent < target)
        begin
            case (k % 10)
                5:       kind = FILE_CUT;
                6:       kind = FILE_BAD_ID;
                7:       kind = FILE_OVERLONG;
                8:       kind = FILE_CORRUPT;
                9:       kind = FILE_NOISE;
                default: kind = FILE_GOOD;
            endcase
            build_file(kind);
            sent += file_bytes.size();
            send_file();
            k++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = 8'd0;
        byte_bus.last_byte = 1'b0;
        reset_parser();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_bad_magic();
        test_bad_version_on_last();
        test_empty_final_section();
        test_drain_pause();
        test_random_files(300);
        stall_en = 1'b0;
        test_random_files(100);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_records.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
